>>> rtl/core/glba_pkg.sv
// shared widths, codes and control/status structs for the glyph line breaker
package glba_pkg;

  localparam int LINE_CAPACITY = 63;
  localparam int FILL_W        = $clog2(LINE_CAPACITY + 1);

  localparam int TAG_W  = 16;
  localparam int ADV_W  = 13;
  localparam int DIM_W  = 12;
  localparam int POS_W  = 16;
  localparam int PEN_W  = 18;
  localparam int LTO_W  = 17;
  localparam int CNT_W  = 16;
  localparam int AW_W   = 15;
  localparam int LH_W   = 12;
  localparam int ALN_W  = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int S_TDATA_W = 56;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 96;
  localparam int M_TUSER_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_MODE  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_OVF   = CFG_IDX_W'(5);

  localparam logic [ALN_W-1:0] ALIGN_LEFT   = ALN_W'(0);
  localparam logic [ALN_W-1:0] ALIGN_RIGHT  = ALN_W'(1);
  localparam logic [ALN_W-1:0] ALIGN_CENTER = ALN_W'(2);

  localparam logic CMD_GLYPH  = 1'b0;
  localparam logic CMD_END    = 1'b1;
  localparam logic KIND_GLYPH = 1'b0;
  localparam logic KIND_BOX   = 1'b1;

  localparam logic [LH_W-1:0] LINE_HEIGHT_RST = LH_W'(16);

  typedef struct packed {
    logic take_in;
    logic calc_align;
    logic calc_base;
    logic rd_entry;
    logic load_glyph;
    logic load_box;
    logic glyph_last;
    logic cap_flag;
    logic close_line;
    logic next_line;
    logic clear_text;
    logic store;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cmd_end;
    logic newline;
    logic overflow;
    logic full;
    logic fill_zero;
    logic idx_last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/core/glba_ctrl.sv
// controller state machine: sequences accept, line close, emission and store
module glba_ctrl import glba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_ALIGN,
    ST_BASE,
    ST_READ,
    ST_EMIT,
    ST_AFTER,
    ST_STORE,
    ST_BOX
  } state_t;

  state_t state, state_next;
  logic   end_mode, end_mode_next;
  logic   cap_mode, cap_mode_next;
  logic   store_after, store_after_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      end_mode    <= 1'b0;
      cap_mode    <= 1'b0;
      store_after <= 1'b0;
    end else begin
      state       <= state_next;
      end_mode    <= end_mode_next;
      cap_mode    <= cap_mode_next;
      store_after <= store_after_next;
    end
  end

  always_comb begin
    cmd              = '0;
    state_next       = state;
    end_mode_next    = end_mode;
    cap_mode_next    = cap_mode;
    store_after_next = store_after;
    s_tready         = 1'b0;
    cmd.cap_flag     = cap_mode;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.take_in = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.cmd_end) begin
          end_mode_next    = 1'b1;
          cap_mode_next    = 1'b0;
          store_after_next = 1'b0;
          state_next       = ST_ALIGN;
        end else if (sts.newline || sts.overflow) begin
          end_mode_next    = 1'b0;
          cap_mode_next    = 1'b0;
          store_after_next = !sts.newline;
          state_next       = ST_ALIGN;
        end else if (sts.full) begin
          end_mode_next    = 1'b0;
          cap_mode_next    = 1'b1;
          store_after_next = 1'b1;
          state_next       = ST_ALIGN;
        end else begin
          state_next = ST_STORE;
        end
      end
      ST_ALIGN: begin
        cmd.calc_align = 1'b1;
        state_next     = ST_BASE;
      end
      ST_BASE: begin
        cmd.calc_base = 1'b1;
        state_next    = sts.fill_zero ? ST_AFTER : ST_READ;
      end
      ST_READ: begin
        cmd.rd_entry = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_glyph = 1'b1;
          cmd.glyph_last = sts.idx_last && !end_mode;
          state_next     = sts.idx_last ? ST_AFTER : ST_READ;
        end
      end
      ST_AFTER: begin
        if (end_mode) begin
          cmd.close_line = 1'b1;
          state_next     = ST_BOX;
        end else begin
          cmd.next_line = 1'b1;
          state_next    = store_after ? ST_STORE : ST_IDLE;
        end
      end
      ST_STORE: begin
        cmd.store  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_BOX: begin
        if (sts.out_free) begin
          cmd.load_box   = 1'b1;
          cmd.clear_text = 1'b1;
          end_mode_next  = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/glba_dp.sv
// datapath: config registers, pen and line state, line buffer, box and result register
module glba_dp import glba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic [S_TUSER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,
  output logic [M_TUSER_W-1:0]  m_tuser,
  output logic                  m_tlast,
  input  ctrl_cmd_t             cmd,
  output dp_sts_t               sts
);

  typedef struct packed {
    logic [TAG_W-1:0]        tag;
    logic signed [PEN_W-1:0] pen;
    logic [DIM_W-1:0]        w;
    logic [DIM_W-1:0]        h;
  } slot_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [23:0] v);
    logic signed [23:0] hi;
    logic signed [23:0] lo;
    hi = 24'sd32767;
    lo = -24'sd32768;
    if (v > hi) begin
      return 16'sh7fff;
    end else if (v < lo) begin
      return 16'sh8000;
    end
    return v[POS_W-1:0];
  endfunction

  // signed halving, truncating toward zero
  function automatic logic signed [PEN_W-1:0] half_tz(input logic signed [PEN_W-1:0] x);
    logic signed [PEN_W:0] t;
    t = PEN_W'(x) + {{PEN_W{1'b0}}, x[PEN_W-1]};
    t = {x[PEN_W-1], x} + {{PEN_W{1'b0}}, x[PEN_W-1]};
    return t[PEN_W:1];
  endfunction

  // config registers
  logic signed [POS_W-1:0] origin_x;
  logic signed [POS_W-1:0] origin_y;
  logic [AW_W-1:0]         area_width;
  logic [LH_W-1:0]         line_height;
  logic [ALN_W-1:0]        align_mode;
  logic                    break_on_overflow;

  // latched request
  logic                    in_end;
  logic                    in_nl;
  logic [TAG_W-1:0]        in_tag;
  logic signed [ADV_W-1:0] in_adv;
  logic [DIM_W-1:0]        in_w;
  logic [DIM_W-1:0]        in_h;

  // text state
  logic signed [PEN_W-1:0] pen;
  logic [LTO_W-1:0]        lto;
  logic [CNT_W-1:0]        line_cnt;
  logic [FILL_W-1:0]       fill;
  logic [FILL_W-1:0]       idx;
  logic signed [POS_W-1:0] box_min_x;
  logic signed [POS_W-1:0] box_min_y;
  logic signed [PEN_W-1:0] box_max_r;
  logic signed [PEN_W-1:0] box_max_b;
  logic                    box_any;

  // line close values
  logic signed [19:0]      d_reg;
  logic signed [20:0]      base_x;
  logic signed [POS_W-1:0] py_line;

  // pending box update
  logic                    upd_valid;
  logic signed [POS_W-1:0] upd_x;
  logic signed [POS_W-1:0] upd_y;
  logic [DIM_W-1:0]        upd_w;
  logic [DIM_W-1:0]        upd_h;

  // line buffer
  slot_t mem [LINE_CAPACITY];
  slot_t rd_data;

  // result register
  logic                    out_valid;
  logic                    o_kind;
  logic [TAG_W-1:0]        o_tag;
  logic [CNT_W-1:0]        o_line;
  logic signed [POS_W-1:0] o_px;
  logic signed [POS_W-1:0] o_py;
  logic signed [POS_W-1:0] o_ew;
  logic signed [POS_W-1:0] o_eh;
  logic                    o_bv;
  logic                    o_cap;
  logic                    o_last;

  logic signed [19:0]      over_sum;
  logic signed [PEN_W-1:0] span;
  logic signed [19:0]      d_next;
  logic signed [19:0]      py_sum;
  logic signed [21:0]      px_sum;
  logic signed [POS_W-1:0] px;
  logic signed [PEN_W:0]   pen_sum;
  logic signed [PEN_W-1:0] pen_sat;
  logic [LTO_W:0]          lto_sum;
  logic signed [PEN_W-1:0] upd_r;
  logic signed [PEN_W-1:0] upd_b;
  logic signed [18:0]      box_w_sum;
  logic signed [18:0]      box_h_sum;

  assign over_sum = 20'(origin_x) + 20'(pen) + signed'(20'(in_w));
  assign span     = signed'(PEN_W'(area_width)) - PEN_W'(origin_x);

  always_comb begin
    case (align_mode)
      ALIGN_RIGHT:  d_next = 20'(span) - 20'(pen);
      ALIGN_CENTER: d_next = 20'(half_tz(span)) - 20'(half_tz(pen));
      default:      d_next = '0;
    endcase
  end

  assign py_sum  = 20'(origin_y) + signed'(20'(lto)) + signed'(20'(line_height));
  assign px_sum  = 22'(base_x) + 22'(rd_data.pen);
  assign px      = sat_pos(24'(px_sum));
  assign pen_sum = (PEN_W+1)'(pen) + (PEN_W+1)'(in_adv);
  assign lto_sum = {1'b0, lto} + (LTO_W+1)'(line_height);
  assign upd_r   = PEN_W'(upd_x) + signed'(PEN_W'(upd_w));
  assign upd_b   = PEN_W'(upd_y) + signed'(PEN_W'(upd_h));

  assign box_w_sum = 19'(box_max_r) - 19'(box_min_x);
  assign box_h_sum = 19'(box_max_b) - 19'(box_min_y);

  always_comb begin
    if (pen_sum > (PEN_W+1)'(131071)) begin
      pen_sat = 18'sh1ffff;
    end else if (pen_sum < -(PEN_W+1)'(131072)) begin
      pen_sat = 18'sh20000;
    end else begin
      pen_sat = pen_sum[PEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x          <= '0;
      origin_y          <= '0;
      area_width        <= '0;
      line_height       <= LINE_HEIGHT_RST;
      align_mode        <= ALIGN_LEFT;
      break_on_overflow <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X:    origin_x          <= cfg_data;
        CFG_ORIGIN_Y:    origin_y          <= cfg_data;
        CFG_AREA_WIDTH:  area_width        <= cfg_data[AW_W-1:0];
        CFG_LINE_HEIGHT: line_height       <= cfg_data[LH_W-1:0];
        CFG_ALIGN_MODE:  align_mode        <= cfg_data[ALN_W-1:0];
        CFG_BREAK_OVF:   break_on_overflow <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      in_end <= s_tuser[0];
      in_nl  <= s_tuser[1];
      in_tag <= s_tdata[15:0];
      in_adv <= s_tdata[28:16];
      in_w   <= s_tdata[40:29];
      in_h   <= s_tdata[52:41];
    end
    if (cmd.calc_align) begin
      d_reg   <= d_next;
      py_line <= sat_pos(24'(py_sum));
    end
    if (cmd.calc_base) begin
      base_x <= 21'(origin_x) + 21'(d_reg);
    end
    if (cmd.load_glyph) begin
      upd_x <= px;
      upd_y <= py_line;
      upd_w <= rd_data.w;
      upd_h <= rd_data.h;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[fill] <= '{tag: in_tag, pen: pen, w: in_w, h: in_h};
    end
    if (cmd.rd_entry) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_text) begin
      pen       <= '0;
      lto       <= '0;
      line_cnt  <= '0;
      fill      <= '0;
      box_min_x <= '0;
      box_min_y <= '0;
      box_max_r <= '0;
      box_max_b <= '0;
      box_any   <= 1'b0;
      idx       <= '0;
      upd_valid <= 1'b0;
    end else begin
      upd_valid <= cmd.load_glyph;
      if (cmd.calc_base) begin
        idx <= '0;
      end else if (cmd.load_glyph) begin
        idx <= idx + FILL_W'(1);
      end
      if (cmd.close_line) begin
        fill <= '0;
      end
      if (cmd.next_line) begin
        fill <= '0;
        pen  <= '0;
        lto  <= lto_sum[LTO_W] ? '1 : lto_sum[LTO_W-1:0];
        if (line_cnt != '1) begin
          line_cnt <= line_cnt + CNT_W'(1);
        end
      end
      if (cmd.store) begin
        fill <= fill + FILL_W'(1);
        pen  <= pen_sat;
      end
      if (upd_valid) begin
        box_any <= 1'b1;
        if (!box_any || upd_x < box_min_x) begin
          box_min_x <= upd_x;
        end
        if (!box_any || upd_y < box_min_y) begin
          box_min_y <= upd_y;
        end
        if (upd_r > box_max_r) begin
          box_max_r <= upd_r;
        end
        if (upd_b > box_max_b) begin
          box_max_b <= upd_b;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_glyph || cmd.load_box) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_glyph) begin
      o_kind <= KIND_GLYPH;
      o_tag  <= rd_data.tag;
      o_line <= line_cnt;
      o_px   <= px;
      o_py   <= py_line;
      o_ew   <= signed'(POS_W'(rd_data.w));
      o_eh   <= signed'(POS_W'(rd_data.h));
      o_bv   <= 1'b0;
      o_cap  <= cmd.cap_flag;
      o_last <= cmd.glyph_last;
    end else if (cmd.load_box) begin
      o_kind <= KIND_BOX;
      o_tag  <= '0;
      o_line <= '0;
      o_px   <= box_any ? box_min_x : '0;
      o_py   <= box_any ? box_min_y : '0;
      o_ew   <= box_any ? sat_pos(24'(box_w_sum)) : '0;
      o_eh   <= box_any ? sat_pos(24'(box_h_sum)) : '0;
      o_bv   <= box_any;
      o_cap  <= 1'b0;
      o_last <= 1'b1;
    end
  end

  assign sts.cmd_end   = (in_end == CMD_END);
  assign sts.newline   = in_nl;
  assign sts.overflow  = break_on_overflow && (over_sum > signed'(20'(area_width)));
  assign sts.full      = (fill == FILL_W'(LINE_CAPACITY));
  assign sts.fill_zero = (fill == '0);
  assign sts.idx_last  = ((idx + FILL_W'(1)) == fill);
  assign sts.out_free  = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {o_eh, o_ew, o_py, o_px, o_line, o_tag};
  assign m_tuser  = {o_cap, o_bv, o_kind};
  assign m_tlast  = o_last;

endmodule

>>> rtl/core/glyph_line_breaker_aligner.sv
// top level of the greedy line breaker with alignment and text bounding box
//
// s_* carries one request per accepted beat: a glyph cluster to place, or an end-of-text
// command. m_* carries placed glyphs and the final bounding box; m_tlast marks the last
// result caused by one request. cfg_* writes the six layout registers, one per cycle;
// the user must write them only while no request is in flight; the block does not enforce it.
//
// A glyph that closes no line passes through the decide and store states and
// produces nothing. A request that closes a line runs the decide, align and base
// states, then a read and an emit state per buffered glyph and an after state,
// plus a store state when the glyph that forced the close is then stored. Each
// glyph is read through the single registered read port of the line buffer first.
// An end command adds a box state after the line, for the box result.
//
// Reset clears the layout registers to their defaults and the text state; the
// line buffer needs no clearing since only entries below the fill count are read.
// When the receiver stalls, the result register holds and the emission loop
// waits; a new request can be accepted while the final result still waits.
module glyph_line_breaker_aligner import glba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,  // glyph_tag, advance_x, glyph_width, glyph_height
  input  logic [S_TUSER_W-1:0]  s_tuser,  // command, is_newline
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,  // out_tag, line_index, pos_x, pos_y, extent_w, extent_h
  output logic [M_TUSER_W-1:0]  m_tuser,  // result_kind, bounds_valid, capacity_break
  output logic                  m_tlast
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  glba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  glba_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> rtl/core/glba_checker.sv
// port-level checker for the line breaker and its bind to the top level
module glba_checker import glba_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [M_TUSER_W-1:0] m_tuser,
  input logic                 m_tlast
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // the box always closes the run
  a_box_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == KIND_BOX) |-> m_tlast)
    else $error("box result without tlast");

  // an empty text gives an all-zero box
  a_empty_box: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == KIND_BOX) && !m_tuser[1] |-> (m_tdata == '0))
    else $error("empty box carries data");

  // glyph results never claim a valid box, box results never a capacity break
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser[0] == KIND_GLYPH) && !m_tuser[1]) ||
                 ((m_tuser[0] == KIND_BOX) && !m_tuser[2]))
    else $error("result flags inconsistent with kind");

endmodule

bind glyph_line_breaker_aligner glba_checker u_glba_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
